[rtl/core/cv5_pkg.sv]
// Shared constants, codes and types of the 5x5 zero-padded convolution unit.
`timescale 1ns / 1ps

package cv5_pkg;

  // Image and kernel geometry.
  localparam int IMG_ROWS = 64;
  localparam int IMG_COLS = 64;
  localparam int KSIZE    = 5;
  localparam int HALF     = KSIZE / 2;
  localparam int TAPS     = KSIZE * KSIZE;
  // Stream positions between a center pixel and the item that completes its window.
  localparam int LAG      = HALF * IMG_COLS + HALF;

  // Field and datapath widths.
  localparam int FUNC_W  = 2;
  localparam int IDX_W   = 5;
  localparam int PIX_W   = 16;
  localparam int PROD_W  = 32;
  localparam int PSUM_W  = 35;
  localparam int SUM_W   = 37;
  localparam int COORD_W = 10;
  localparam int COL_AW  = $clog2(IMG_COLS);
  localparam int FILL_W  = $clog2(LAG + 1);
  localparam int LB_W    = (KSIZE - 1) * PIX_W;

  // Item kinds carried on the input tuser.
  typedef enum logic [FUNC_W-1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_PIXEL  = 2'd1,
    FUNC_FLUSH  = 2'd2
  } func_t;

  // One classified item in the queue between front and back.
  typedef struct packed {
    logic             is_weight;
    logic [IDX_W-1:0] idx;
    logic [PIX_W-1:0] value;
  } item_t;

  // Center information that travels down the arithmetic pipeline.
  typedef struct packed {
    logic               valid;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic               last;
  } meta_t;

  // Window or weight set, tap row*KSIZE+col.
  typedef logic [TAPS-1:0][PIX_W-1:0] tap_vec_t;

endpackage

[rtl/core/cv5_ram.sv]
// Generic simple dual-port RAM with a registered read.
`timescale 1ns / 1ps

module cv5_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/cv5_front.sv]
// Front end: accepts beats, drops unused codes and bad weight indices, queues items.
`timescale 1ns / 1ps

module cv5_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_valid,
  output logic                       s_ready,
  input  logic [cv5_pkg::FUNC_W-1:0] s_func,
  input  logic [cv5_pkg::IDX_W-1:0]  s_idx,
  input  logic [cv5_pkg::PIX_W-1:0]  s_wt,
  input  logic [cv5_pkg::PIX_W-1:0]  s_pix,
  output cv5_pkg::item_t             q_item,
  output logic                       q_valid,
  input  logic                       q_pop
);

  cv5_pkg::item_t item_in;
  logic           item_keep;
  logic           push;
  cv5_pkg::item_t slot [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     count;

  // Classify the incoming beat.
  always_comb begin
    item_in   = '0;
    item_keep = 1'b0;
    case (cv5_pkg::func_t'(s_func))
      cv5_pkg::FUNC_WEIGHT: begin
        item_in.is_weight = 1'b1;
        item_in.idx       = s_idx;
        item_in.value     = s_wt;
        item_keep         = (s_idx < cv5_pkg::IDX_W'(cv5_pkg::TAPS));
      end
      cv5_pkg::FUNC_PIXEL: begin
        item_in.value = s_pix;
        item_keep     = 1'b1;
      end
      cv5_pkg::FUNC_FLUSH: begin
        item_keep = 1'b1;
      end
      default: begin
        item_keep = 1'b0;
      end
    endcase
  end

  assign s_ready = (count != 2'd2);
  assign push    = s_valid & s_ready & item_keep;
  assign q_valid = (count != 2'd0);
  assign q_item  = slot[rd_ptr];

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !q_pop) begin
        count <= count + 2'd1;
      end else if (!push && q_pop) begin
        count <= count - 2'd1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= item_in;
    end
  end

endmodule

[rtl/core/cv5_window.sv]
// Back end, first stage: weight table, line buffers, 5x5 window and raster counters.
`timescale 1ns / 1ps

module cv5_window (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              q_valid,
  input  cv5_pkg::item_t    q_item,
  output logic              q_pop,
  output cv5_pkg::tap_vec_t win,
  output cv5_pkg::tap_vec_t wts,
  output cv5_pkg::meta_t    meta
);

  logic                        take;
  logic                        stream;
  logic                        frame_end;
  logic [cv5_pkg::COL_AW-1:0]  scol;
  logic [cv5_pkg::COL_AW-1:0]  scol_next;
  logic [cv5_pkg::COL_AW-1:0]  raddr;
  logic [cv5_pkg::FILL_W-1:0]  fill;
  logic [cv5_pkg::COORD_W-1:0] crow;
  logic [cv5_pkg::COORD_W-1:0] ccol;
  logic [cv5_pkg::LB_W-1:0]    lb_rd;
  logic [cv5_pkg::LB_W-1:0]    lb_wr;
  logic                        emit;

  assign take   = en & q_valid;
  assign q_pop  = take;
  assign stream = take & ~q_item.is_weight;
  assign emit   = (fill == cv5_pkg::FILL_W'(cv5_pkg::LAG));

  assign frame_end = emit
                     && (crow == cv5_pkg::COORD_W'(cv5_pkg::IMG_ROWS - 1))
                     && (ccol == cv5_pkg::COORD_W'(cv5_pkg::IMG_COLS - 1));

  // Column of the next stream beat; the frame restarts at column zero.
  always_comb begin
    if (frame_end || scol == cv5_pkg::COL_AW'(cv5_pkg::IMG_COLS - 1)) begin
      scol_next = '0;
    end else begin
      scol_next = scol + 1'b1;
    end
  end

  // Read ahead so the line data for the next beat is ready when it arrives.
  assign raddr = stream ? scol_next : scol;
  // Older rows move up one line; the new pixel enters the newest line.
  assign lb_wr = {lb_rd[cv5_pkg::LB_W-cv5_pkg::PIX_W-1:0], q_item.value};

  cv5_ram #(
    .WIDTH (cv5_pkg::LB_W),
    .DEPTH (cv5_pkg::IMG_COLS)
  ) u_lines (
    .clk   (clk),
    .we    (stream),
    .waddr (scol),
    .wdata (lb_wr),
    .raddr (raddr),
    .rdata (lb_rd)
  );

  // Raster counters and the center tag of the beat that completes a window.
  always_ff @(posedge clk) begin
    if (rst) begin
      scol       <= '0;
      fill       <= '0;
      crow       <= '0;
      ccol       <= '0;
      meta.valid <= 1'b0;
    end else if (en) begin
      meta.valid <= stream & emit;
      if (stream) begin
        meta.row  <= crow;
        meta.col  <= ccol;
        meta.last <= frame_end;
        scol      <= scol_next;
        if (!emit) begin
          fill <= fill + 1'b1;
        end else if (frame_end) begin
          fill <= '0;
          crow <= '0;
          ccol <= '0;
        end else if (ccol == cv5_pkg::COORD_W'(cv5_pkg::IMG_COLS - 1)) begin
          ccol <= '0;
          crow <= crow + 1'b1;
        end else begin
          ccol <= ccol + 1'b1;
        end
      end
    end
  end

  // Window shift and weight writes.
  always_ff @(posedge clk) begin
    if (take && q_item.is_weight) begin
      wts[q_item.idx] <= q_item.value;
    end
    if (stream) begin
      for (int i = 0; i < cv5_pkg::KSIZE; i++) begin
        for (int j = 0; j < cv5_pkg::KSIZE - 1; j++) begin
          win[i*cv5_pkg::KSIZE+j] <= win[i*cv5_pkg::KSIZE+j+1];
        end
      end
      for (int i = 0; i < cv5_pkg::KSIZE - 1; i++) begin
        win[i*cv5_pkg::KSIZE+cv5_pkg::KSIZE-1] <=
          lb_rd[(cv5_pkg::KSIZE-2-i)*cv5_pkg::PIX_W +: cv5_pkg::PIX_W];
      end
      win[cv5_pkg::TAPS-1] <= q_item.value;
    end
  end

endmodule

[rtl/core/cv5_mac.sv]
// Back end, arithmetic: edge masking, 25 products, two adder levels and the output register.
`timescale 1ns / 1ps

module cv5_mac (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        en,
  input  cv5_pkg::tap_vec_t           win,
  input  cv5_pkg::tap_vec_t           wts,
  input  cv5_pkg::meta_t              meta_a,
  output cv5_pkg::meta_t              meta_out,
  output logic [cv5_pkg::SUM_W-1:0]   sum_out
);

  logic [cv5_pkg::KSIZE-1:0]         row_ok;
  logic [cv5_pkg::KSIZE-1:0]         col_ok;
  logic signed [cv5_pkg::PROD_W-1:0] prod_next [cv5_pkg::TAPS];
  logic signed [cv5_pkg::PROD_W-1:0] prod      [cv5_pkg::TAPS];
  logic signed [cv5_pkg::PSUM_W-1:0] psum_next [cv5_pkg::KSIZE];
  logic signed [cv5_pkg::PSUM_W-1:0] psum      [cv5_pkg::KSIZE];
  logic signed [cv5_pkg::SUM_W-1:0]  total_next;
  cv5_pkg::meta_t                    meta_b;
  cv5_pkg::meta_t                    meta_c;

  // Taps that fall outside the image contribute zero.
  always_comb begin
    logic signed [cv5_pkg::COORD_W+1:0] rr;
    logic signed [cv5_pkg::COORD_W+1:0] cc;
    for (int i = 0; i < cv5_pkg::KSIZE; i++) begin
      rr = $signed({2'b00, meta_a.row}) + $signed((cv5_pkg::COORD_W+2)'(i - cv5_pkg::HALF));
      cc = $signed({2'b00, meta_a.col}) + $signed((cv5_pkg::COORD_W+2)'(i - cv5_pkg::HALF));
      row_ok[i] = (rr >= 0) && (rr < $signed((cv5_pkg::COORD_W+2)'(cv5_pkg::IMG_ROWS)));
      col_ok[i] = (cc >= 0) && (cc < $signed((cv5_pkg::COORD_W+2)'(cv5_pkg::IMG_COLS)));
    end
  end

  // One multiplier per tap.
  always_comb begin
    for (int i = 0; i < cv5_pkg::KSIZE; i++) begin
      for (int j = 0; j < cv5_pkg::KSIZE; j++) begin
        if (row_ok[i] && col_ok[j]) begin
          prod_next[i*cv5_pkg::KSIZE+j] = $signed(win[i*cv5_pkg::KSIZE+j])
                                         * $signed(wts[i*cv5_pkg::KSIZE+j]);
        end else begin
          prod_next[i*cv5_pkg::KSIZE+j] = '0;
        end
      end
    end
  end

  // Row sums of five products each.
  always_comb begin
    for (int i = 0; i < cv5_pkg::KSIZE; i++) begin
      psum_next[i] = '0;
      for (int j = 0; j < cv5_pkg::KSIZE; j++) begin
        psum_next[i] = psum_next[i] + cv5_pkg::PSUM_W'(prod[i*cv5_pkg::KSIZE+j]);
      end
    end
  end

  // Final sum of the row sums.
  always_comb begin
    total_next = '0;
    for (int i = 0; i < cv5_pkg::KSIZE; i++) begin
      total_next = total_next + cv5_pkg::SUM_W'(psum[i]);
    end
  end

  // Pipeline tags: valid bits and center coordinates.
  always_ff @(posedge clk) begin
    if (rst) begin
      meta_b.valid   <= 1'b0;
      meta_c.valid   <= 1'b0;
      meta_out.valid <= 1'b0;
    end else if (en) begin
      meta_b.valid   <= meta_a.valid;
      meta_c.valid   <= meta_b.valid;
      meta_out.valid <= meta_c.valid;
      meta_b.row     <= meta_a.row;
      meta_b.col     <= meta_a.col;
      meta_b.last    <= meta_a.last;
      meta_c.row     <= meta_b.row;
      meta_c.col     <= meta_b.col;
      meta_c.last    <= meta_b.last;
      meta_out.row   <= meta_c.row;
      meta_out.col   <= meta_c.col;
      meta_out.last  <= meta_c.last;
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (en) begin
      prod    <= prod_next;
      psum    <= psum_next;
      sum_out <= total_next;
    end
  end

endmodule

[rtl/core/conv5x5_same_padding_unit.sv]
// Top level of the 5x5 same-size convolution with zero padding.
//
//  channel  | direction | tdata / tuser / tlast
//  s_axis   | in        | tdata: weight_index, weight_value, pixel_value; tuser: func
//  m_axis   | out       | tdata: conv_sum, out_row, out_col; tlast: last_of_frame
//
// One item per cycle is accepted while the output is not stalled; the line buffer RAM
// has one write and one read port, so a new pixel or flush beat need not wait on it.
// A result passes the window tag, product, row-sum and output registers after its last beat.
// Reset clears queue, counters and pipeline valids; weights and line data are not cleared.
// A stalled output holds the whole back end; the two-entry queue takes beats until full.
`timescale 1ns / 1ps

module conv5x5_same_padding_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // weight_index[4:0], weight_value[20:5], pixel_value[36:21]
  input  logic [1:0]  s_axis_tuser,   // func[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [63:0] m_axis_tdata,   // conv_sum[36:0], out_row[46:37], out_col[56:47]
  output logic        m_axis_tlast
);

  logic                          en;
  logic                          q_valid;
  logic                          q_pop;
  cv5_pkg::item_t                q_item;
  cv5_pkg::tap_vec_t             win;
  cv5_pkg::tap_vec_t             wts;
  cv5_pkg::meta_t                meta_a;
  cv5_pkg::meta_t                meta_out;
  logic [cv5_pkg::SUM_W-1:0]     sum_out;

  // The back end advances whenever the output register is free or being taken.
  assign en = ~meta_out.valid | m_axis_tready;

  cv5_front u_front (
    .clk     (clk),
    .rst     (rst),
    .s_valid (s_axis_tvalid),
    .s_ready (s_axis_tready),
    .s_func  (s_axis_tuser),
    .s_idx   (s_axis_tdata[4:0]),
    .s_wt    (s_axis_tdata[20:5]),
    .s_pix   (s_axis_tdata[36:21]),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_pop   (q_pop)
  );

  cv5_window u_window (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .q_valid (q_valid),
    .q_item  (q_item),
    .q_pop   (q_pop),
    .win     (win),
    .wts     (wts),
    .meta    (meta_a)
  );

  cv5_mac u_mac (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .win      (win),
    .wts      (wts),
    .meta_a   (meta_a),
    .meta_out (meta_out),
    .sum_out  (sum_out)
  );

  assign m_axis_tvalid = meta_out.valid;
  assign m_axis_tlast  = meta_out.last;
  assign m_axis_tdata  = {7'd0, meta_out.col, meta_out.row, sum_out};

  // The frame marker sits exactly on the bottom-right center.
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |->
      (m_axis_tdata[46:37] == cv5_pkg::COORD_W'(cv5_pkg::IMG_ROWS - 1)) &&
      (m_axis_tdata[56:47] == cv5_pkg::COORD_W'(cv5_pkg::IMG_COLS - 1)))
    else $error("frame marker on a center other than the last");

  a_last_needed: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tlast |->
      !((m_axis_tdata[46:37] == cv5_pkg::COORD_W'(cv5_pkg::IMG_ROWS - 1)) &&
        (m_axis_tdata[56:47] == cv5_pkg::COORD_W'(cv5_pkg::IMG_COLS - 1))))
    else $error("last center without frame marker");

  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

endmodule
